// ===== sv/bgc_pkg.sv =====
// bgc_pkg: types, constants and the cell reciprocal table of the battery gauge classifier
// used by every module of the block; depends on nothing
`default_nettype none

package bgc_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_RESISTANCE = 3'd0;
    localparam logic [2:0] REG_CELL_COUNT = 3'd1;
    localparam logic [2:0] REG_OVERVOLT   = 3'd2;
    localparam logic [2:0] REG_FULL       = 3'd3;
    localparam logic [2:0] REG_ONE_BAR    = 3'd4;
    localparam logic [2:0] REG_EMPTY      = 3'd5;

    localparam logic [1:0] STATUS_NORMAL = 2'd0;
    localparam logic [1:0] STATUS_UNDER  = 2'd1;
    localparam logic [1:0] STATUS_OVER   = 2'd2;

    localparam logic [3:0] LEVEL_EMPTY = 4'd0;
    localparam logic [3:0] LEVEL_FULL  = 4'd12;

    localparam logic [12:0] CELL_BASE = 13'd200;
    localparam logic [7:0]  MAP_WIDE  = 8'd10;

    localparam int NUM_W  = 12;
    localparam int DEN_W  = 9;
    localparam int QUOT_W = 4;

    localparam logic [NUM_W-1:0] MAP_STEPS_WIDE   = NUM_W'(11);
    localparam logic [NUM_W-1:0] MAP_STEPS_NARROW = NUM_W'(10);

    // exact reciprocal constants for the fixed divisions
    localparam logic [18:0] DIV10_M18   = 19'd419431;
    localparam int          DIV10_S18   = 22;
    localparam logic [15:0] DIV10_M16   = 16'd52429;
    localparam int          DIV10_S16   = 19;
    localparam logic [24:0] DIV1000_M   = 25'd17179870;
    localparam int          DIV1000_S   = 34;
    localparam int          CELL_S      = 17;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [9:0] pack_resistance_milliohm;
        logic [3:0] cell_count;
        logic [7:0] overvolt_threshold;
        logic [7:0] full_threshold;
        logic [7:0] one_bar_threshold;
        logic [7:0] empty_threshold;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        pack_resistance_milliohm: 10'd180,
        cell_count:               4'd10,
        overvolt_threshold:       8'd225,
        full_threshold:           8'd200,
        one_bar_threshold:        8'd130,
        empty_threshold:          8'd100
    };

    typedef struct packed {
        logic [15:0] raw_voltage_mv;
        logic [7:0]  current_tenths;
    } t_in;

    typedef struct packed {
        logic [15:0] comp_voltage_mv;
        logic [14:0] power_tenths_watt;
        logic [3:0]  charge_level;
        logic [1:0]  battery_status;
    } t_out;

    typedef struct packed {
        logic [15:0]      comp_voltage_mv;
        logic [14:0]      power_tenths_watt;
        logic [3:0]       charge_level;
        logic [1:0]       battery_status;
        logic             use_div;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_job;

    // ceil(2^17 / cells); zero cells behaves as one cell
    function automatic logic [17:0] recip_cell(input logic [3:0] cells);
        logic [17:0] m;
        case (cells)
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd5:    m = 18'd26215;
            4'd6:    m = 18'd21846;
            4'd7:    m = 18'd18725;
            4'd8:    m = 18'd16384;
            4'd9:    m = 18'd14564;
            4'd10:   m = 18'd13108;
            4'd11:   m = 18'd11916;
            4'd12:   m = 18'd10923;
            4'd13:   m = 18'd10083;
            4'd14:   m = 18'd9363;
            4'd15:   m = 18'd8739;
            default: m = 18'd131072;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== sv/battery_gauge_classifier.sv =====
// battery_gauge_classifier: top level with the configuration registers, front pipeline,
// job queue and divider back end; depends on bgc_pkg, bgc_front, bgc_queue, bgc_back
//
// Usage:
//   Input channel (i_in_valid, o_in_ready, i_in_data) takes one pack report per request:
//   raw voltage and current. Output channel (o_out_valid, i_out_ready, o_out_data) gives
//   one result per request, in order: compensated voltage, power, bar level and status.
//   Throughput is one request per cycle while the output is not stalled. A request passes
//   six front stages (compensation, power and per-cell multiplies, classification),
//   the job queue and four divider stages that produce the bar map quotient one bit per
//   stage, the last being the output register.
//   When the receiver stalls, the back end holds and the front keeps filling the queue;
//   o_in_ready falls once the queue is full and the last front stage holds a job.
//   Reset clears the valid flags and queue pointers and loads the register defaults. The APB
//   registers may be written only while no request is in flight.
`default_nettype none

module battery_gauge_classifier #(
    parameter int QUEUE_DEPTH = bgc_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  bgc_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output bgc_pkg::t_out               o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bgc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bgc_pkg::DATA_W-1:0]  pwdata,
    output logic [bgc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    bgc_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [2:0]    w_idx;

    logic          w_fq_valid;
    logic          w_fq_ready;
    bgc_pkg::t_job w_fq_job;
    logic          w_qb_valid;
    logic          w_qb_ready;
    bgc_pkg::t_job w_qb_job;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bgc_pkg::CFG_RESET;
        end else if (w_wr) begin
            case (w_idx)
                bgc_pkg::REG_RESISTANCE: r_cfg.pack_resistance_milliohm <= pwdata[9:0];
                bgc_pkg::REG_CELL_COUNT: r_cfg.cell_count               <= pwdata[3:0];
                bgc_pkg::REG_OVERVOLT:   r_cfg.overvolt_threshold       <= pwdata[7:0];
                bgc_pkg::REG_FULL:       r_cfg.full_threshold           <= pwdata[7:0];
                bgc_pkg::REG_ONE_BAR:    r_cfg.one_bar_threshold        <= pwdata[7:0];
                bgc_pkg::REG_EMPTY:      r_cfg.empty_threshold          <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            bgc_pkg::REG_RESISTANCE: prdata = 32'(r_cfg.pack_resistance_milliohm);
            bgc_pkg::REG_CELL_COUNT: prdata = 32'(r_cfg.cell_count);
            bgc_pkg::REG_OVERVOLT:   prdata = 32'(r_cfg.overvolt_threshold);
            bgc_pkg::REG_FULL:       prdata = 32'(r_cfg.full_threshold);
            bgc_pkg::REG_ONE_BAR:    prdata = 32'(r_cfg.one_bar_threshold);
            bgc_pkg::REG_EMPTY:      prdata = 32'(r_cfg.empty_threshold);
            default:                 prdata = '0;
        endcase
    end

    bgc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_fq_valid),
        .i_ready (w_fq_ready),
        .o_job   (w_fq_job)
    );

    bgc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_job   (w_fq_job),
        .o_valid (w_qb_valid),
        .i_ready (w_qb_ready),
        .o_job   (w_qb_job)
    );

    bgc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qb_valid),
        .o_ready (w_qb_ready),
        .i_job   (w_qb_job),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.charge_level <= bgc_pkg::LEVEL_FULL)
        else $error("charge level above full");

    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.battery_status == bgc_pkg::STATUS_OVER
        |-> o_out_data.charge_level == bgc_pkg::LEVEL_FULL)
        else $error("overvoltage result not at full level");

    a_under_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.battery_status == bgc_pkg::STATUS_UNDER
        |-> o_out_data.charge_level == bgc_pkg::LEVEL_EMPTY)
        else $error("undervoltage result not at empty level");

    a_queue_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fq_ready |-> w_qb_valid)
        else $error("queue full but no job offered to back end");
`endif

endmodule

`default_nettype wire

// ===== sv/bgc_front.sv =====
// bgc_front: six-stage pipeline that compensates voltage, computes power and per-cell value
// and classifies each request into a job for the back end; depends on bgc_pkg
`default_nettype none

module bgc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bgc_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  bgc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bgc_pkg::t_job o_job
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] r_vld;
    logic              w_en;

    logic [17:0] n_a_prod, r_a_prod;
    logic [15:0] r_a_raw;
    logic [7:0]  r_a_cur;

    logic [36:0] w_b_mul;
    logic [14:0] n_b_drop, r_b_drop;
    logic [15:0] r_b_raw;
    logic [7:0]  r_b_cur;

    logic [16:0] w_c_sum;
    logic [15:0] n_c_volt, r_c_volt;
    logic [7:0]  r_c_cur;

    logic [34:0] w_d_mul;
    logic [23:0] n_d_pprod, r_d_pprod;
    logic [12:0] n_d_d10, r_d_d10;
    logic [15:0] r_d_volt;

    logic [48:0] w_e_pmul;
    logic [30:0] w_e_cmul;
    logic [14:0] n_e_power, r_e_power;
    logic [12:0] n_e_pc, r_e_pc;
    logic [15:0] r_e_volt;

    logic [12:0]   w_f_v;
    logic [7:0]    w_f_span;
    logic [7:0]    w_f_off;
    bgc_pkg::t_job n_f_job, r_f_job;

    assign w_en    = !r_vld[STAGES-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[STAGES-1];
    assign o_job   = r_f_job;

    assign n_a_prod = 18'(i_data.current_tenths) * 18'(i_cfg.pack_resistance_milliohm);

    assign w_b_mul  = 37'(r_a_prod) * 37'(bgc_pkg::DIV10_M18);
    assign n_b_drop = 15'(w_b_mul >> bgc_pkg::DIV10_S18);

    assign w_c_sum  = 17'(r_b_raw) + 17'(r_b_drop);
    assign n_c_volt = w_c_sum[16] ? 16'hFFFF : w_c_sum[15:0];

    assign n_d_pprod = 24'(r_c_volt) * 24'(r_c_cur);
    assign w_d_mul   = 35'(r_c_volt) * 35'(bgc_pkg::DIV10_M16);
    assign n_d_d10   = 13'(w_d_mul >> bgc_pkg::DIV10_S16);

    assign w_e_pmul  = 49'(r_d_pprod) * 49'(bgc_pkg::DIV1000_M);
    assign n_e_power = 15'(w_e_pmul >> bgc_pkg::DIV1000_S);
    assign w_e_cmul  = 31'(r_d_d10) * 31'(bgc_pkg::recip_cell(i_cfg.cell_count));
    assign n_e_pc    = 13'(w_e_cmul >> bgc_pkg::CELL_S);

    always_comb begin
        w_f_v    = r_e_pc - bgc_pkg::CELL_BASE;
        w_f_span = i_cfg.full_threshold - i_cfg.one_bar_threshold;
        w_f_off  = w_f_v[7:0] - i_cfg.one_bar_threshold;

        n_f_job                   = '0;
        n_f_job.comp_voltage_mv   = r_e_volt;
        n_f_job.power_tenths_watt = r_e_power;
        n_f_job.charge_level      = bgc_pkg::LEVEL_EMPTY;
        n_f_job.battery_status    = bgc_pkg::STATUS_NORMAL;

        if (r_e_pc <= bgc_pkg::CELL_BASE) begin
            n_f_job.battery_status = bgc_pkg::STATUS_UNDER;
        end else if (w_f_v >= 13'(i_cfg.overvolt_threshold)) begin
            n_f_job.charge_level   = bgc_pkg::LEVEL_FULL;
            n_f_job.battery_status = bgc_pkg::STATUS_OVER;
        end else if (w_f_v >= 13'(i_cfg.full_threshold)) begin
            n_f_job.charge_level = bgc_pkg::LEVEL_FULL;
        end else if (w_f_v <= 13'(i_cfg.empty_threshold)) begin
            n_f_job.battery_status = bgc_pkg::STATUS_UNDER;
        end else if (w_f_v < 13'(i_cfg.one_bar_threshold)) begin
            n_f_job.charge_level = bgc_pkg::LEVEL_EMPTY;
        end else begin
            // linear bar map, finished by the divider in the back end
            n_f_job.use_div = 1'b1;
            if (w_f_span > bgc_pkg::MAP_WIDE) begin
                n_f_job.num = bgc_pkg::NUM_W'(w_f_off) * bgc_pkg::MAP_STEPS_WIDE;
                n_f_job.den = bgc_pkg::DEN_W'(w_f_span) + bgc_pkg::DEN_W'(1);
            end else begin
                n_f_job.num = bgc_pkg::NUM_W'(w_f_off) * bgc_pkg::MAP_STEPS_NARROW;
                n_f_job.den = bgc_pkg::DEN_W'(w_f_span);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_prod  <= n_a_prod;
            r_a_raw   <= i_data.raw_voltage_mv;
            r_a_cur   <= i_data.current_tenths;
            r_b_drop  <= n_b_drop;
            r_b_raw   <= r_a_raw;
            r_b_cur   <= r_a_cur;
            r_c_volt  <= n_c_volt;
            r_c_cur   <= r_b_cur;
            r_d_pprod <= n_d_pprod;
            r_d_d10   <= n_d_d10;
            r_d_volt  <= r_c_volt;
            r_e_power <= n_e_power;
            r_e_pc    <= n_e_pc;
            r_e_volt  <= r_d_volt;
            r_f_job   <= n_f_job;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bgc_queue.sv =====
// bgc_queue: small job queue between the front and back pipelines
// depends on bgc_pkg for the job type
`default_nettype none

module bgc_queue #(
    parameter int DEPTH = bgc_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bgc_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output bgc_pkg::t_job o_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bgc_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = r_cnt != CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bgc_back.sv =====
// bgc_back: pipelined restoring divider, one quotient bit per stage, that finishes the bar map
// its last stage is the output register; depends on bgc_pkg
`default_nettype none

module bgc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bgc_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output bgc_pkg::t_out o_data
);

    localparam int NS = bgc_pkg::QUOT_W;

    typedef struct packed {
        bgc_pkg::t_job             job;
        logic [bgc_pkg::QUOT_W-1:0] quot;
    } t_bst;

    logic [NS-1:0]             r_bv;
    t_bst                      r_bs  [NS];
    t_bst                      n_bs  [NS];
    t_bst                      w_src [NS];
    logic [bgc_pkg::NUM_W-1:0] w_trial [NS];
    logic                      w_en;

    assign w_en    = !r_bv[NS-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_bv[NS-1];

    assign o_data.comp_voltage_mv   = r_bs[NS-1].job.comp_voltage_mv;
    assign o_data.power_tenths_watt = r_bs[NS-1].job.power_tenths_watt;
    assign o_data.charge_level      = r_bs[NS-1].job.charge_level;
    assign o_data.battery_status    = r_bs[NS-1].job.battery_status;

    always_comb begin
        w_src[0].job  = i_job;
        w_src[0].quot = '0;
        for (int k = 1; k < NS; k++) begin
            w_src[k] = r_bs[k-1];
        end
        for (int k = 0; k < NS; k++) begin
            w_trial[k] = bgc_pkg::NUM_W'(w_src[k].job.den) << (NS - 1 - k);
            n_bs[k]    = w_src[k];
            if (w_src[k].job.num >= w_trial[k]) begin
                n_bs[k].job.num          = w_src[k].job.num - w_trial[k];
                n_bs[k].quot[NS - 1 - k] = 1'b1;
            end
        end
        if (n_bs[NS-1].job.use_div) begin
            n_bs[NS-1].job.charge_level = 4'(n_bs[NS-1].quot) + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (w_en) begin
            r_bv <= {r_bv[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NS; k++) begin
                r_bs[k] <= n_bs[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for battery_gauge_classifier, driving pack reports over
// valid/ready and registers over APB, and checking every result against its own predictor
// depends on bgc_pkg and battery_gauge_classifier
module testbench;
    import bgc_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam int VOLT_SAT = 65535;
    localparam int DROP_SCALE = 10;
    localparam int CELL_SCALE = 10;
    localparam int POWER_SCALE = 1000;
    localparam int PER_CELL_FLOOR = 200;
    localparam int MAP_NARROW_MAX = 10;
    localparam int MAP_BARS_WIDE = 11;
    localparam int MAP_BARS_NARROW = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SETTINGS_PER_MODE = 7;
    localparam int ITEMS_PER_SETTING = 50;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in in_data = '0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    t_cfg gauge_cfg = CFG_RESET;
    t_out pending_results[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    battery_gauge_classifier dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int cells_in_use(input t_cfg c);
        return (c.cell_count == 4'd0) ? 1 : int'(c.cell_count);
    endfunction

    function automatic t_out gauge_expect(input t_in rep, input t_cfg c);
        int drop;
        int volt;
        int per_cell;
        int v;
        int span;
        t_out res;
        res.charge_level = LEVEL_EMPTY;
        res.battery_status = STATUS_NORMAL;
        drop = int'(rep.current_tenths) * int'(c.pack_resistance_milliohm) / DROP_SCALE;
        volt = int'(rep.raw_voltage_mv) + drop;
        if (volt > VOLT_SAT) volt = VOLT_SAT;
        per_cell = volt / CELL_SCALE / cells_in_use(c);
        res.comp_voltage_mv = 16'(volt);
        res.power_tenths_watt = 15'(volt * int'(rep.current_tenths) / POWER_SCALE);
        if (per_cell <= PER_CELL_FLOOR) begin
            res.battery_status = STATUS_UNDER;
        end else begin
            v = per_cell - PER_CELL_FLOOR;
            if (v >= int'(c.overvolt_threshold)) begin
                res.charge_level = LEVEL_FULL;
                res.battery_status = STATUS_OVER;
            end else if (v >= int'(c.full_threshold)) begin
                res.charge_level = LEVEL_FULL;
            end else if (v <= int'(c.empty_threshold)) begin
                res.battery_status = STATUS_UNDER;
            end else if (v >= int'(c.one_bar_threshold)) begin
                span = int'(c.full_threshold) - int'(c.one_bar_threshold);
                v = v - int'(c.one_bar_threshold);
                if (span > MAP_NARROW_MAX) begin
                    res.charge_level = 4'(v * MAP_BARS_WIDE / (span + 1) + 1);
                end else begin
                    res.charge_level = 4'(v * MAP_BARS_NARROW / span + 1);
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // result check first, then prediction of a newly accepted request
    always @(posedge clk) begin : result_check
        t_out want;
        if (out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", out_data));
            end else begin
                want = pending_results.pop_front();
                check_field("comp_voltage_mv", 32'(out_data.comp_voltage_mv),
                            32'(want.comp_voltage_mv));
                check_field("power_tenths_watt", 32'(out_data.power_tenths_watt),
                            32'(want.power_tenths_watt));
                check_field("charge_level", 32'(out_data.charge_level),
                            32'(want.charge_level));
                check_field("battery_status", 32'(out_data.battery_status),
                            32'(want.battery_status));
            end
        end
        if (in_valid && in_ready) begin
            pending_results.push_back(gauge_expect(in_data, gauge_cfg));
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_report(input logic [15:0] raw, input logic [7:0] cur);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{raw_voltage_mv: raw, current_tenths: cur};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // no current, so the per-cell value lands exactly on v above the floor
    task automatic send_cell_value(input int v);
        send_report(16'((PER_CELL_FLOOR + v) * CELL_SCALE * cells_in_use(gauge_cfg)), 8'd0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RESISTANCE: gauge_cfg.pack_resistance_milliohm = value[9:0];
            REG_CELL_COUNT: gauge_cfg.cell_count = value[3:0];
            REG_OVERVOLT:   gauge_cfg.overvolt_threshold = value[7:0];
            REG_FULL:       gauge_cfg.full_threshold = value[7:0];
            REG_ONE_BAR:    gauge_cfg.one_bar_threshold = value[7:0];
            REG_EMPTY:      gauge_cfg.empty_threshold = value[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_config(input t_cfg c);
        settle();
        apb_write(REG_RESISTANCE, 32'(c.pack_resistance_milliohm));
        apb_write(REG_CELL_COUNT, 32'(c.cell_count));
        apb_write(REG_OVERVOLT, 32'(c.overvolt_threshold));
        apb_write(REG_FULL, 32'(c.full_threshold));
        apb_write(REG_ONE_BAR, 32'(c.one_bar_threshold));
        apb_write(REG_EMPTY, 32'(c.empty_threshold));
    endtask

    function automatic t_cfg random_config();
        t_cfg c;
        c.pack_resistance_milliohm = 10'($urandom_range(0, 1023));
        c.cell_count = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 4) != 0) begin
            c.empty_threshold = 8'($urandom_range(0, 200));
            c.one_bar_threshold = 8'($urandom_range(c.empty_threshold, 230));
            c.full_threshold = 8'($urandom_range(c.one_bar_threshold, 250));
            c.overvolt_threshold = 8'($urandom_range(c.full_threshold, 255));
        end else begin
            c.empty_threshold = 8'($urandom);
            c.one_bar_threshold = 8'($urandom);
            c.full_threshold = 8'($urandom);
            c.overvolt_threshold = 8'($urandom);
        end
        return c;
    endfunction

    // most reports aim at a per-cell value near a decision point or inside the bar map range
    function automatic t_in random_report(input t_cfg c);
        t_in rep;
        int pick;
        int cells;
        int per_cell;
        int volt;
        int drop;
        rep.raw_voltage_mv = 16'($urandom);
        rep.current_tenths = 8'($urandom);
        pick = $urandom_range(0, 9);
        cells = cells_in_use(c);
        if (pick >= 4) begin
            case (pick)
                4: per_cell = PER_CELL_FLOOR;
                5: per_cell = PER_CELL_FLOOR + int'(c.empty_threshold);
                6: per_cell = PER_CELL_FLOOR + int'(c.one_bar_threshold);
                7: per_cell = PER_CELL_FLOOR + int'(c.full_threshold);
                8: per_cell = PER_CELL_FLOOR + int'(c.overvolt_threshold);
                default: per_cell = PER_CELL_FLOOR +
                    int'($urandom_range(c.one_bar_threshold, c.full_threshold));
            endcase
            if (pick != 9) per_cell = per_cell + int'($urandom_range(0, 4)) - 2;
            volt = per_cell * CELL_SCALE * cells + int'($urandom_range(0, CELL_SCALE * cells - 1));
            if (volt <= VOLT_SAT) begin
                drop = int'(rep.current_tenths) * int'(c.pack_resistance_milliohm) / DROP_SCALE;
                if (drop > volt) begin
                    rep.current_tenths = 8'd0;
                    drop = 0;
                end
                rep.raw_voltage_mv = 16'(volt - drop);
            end
        end
        return rep;
    endfunction

    task automatic test_reset_defaults();
        int cell_values[9] = '{100, 101, 130, 165, 199, 200, 224, 225, 300};
        send_report(16'd0, 8'd0);
        send_report(16'hFFFF, 8'hFF);
        send_report(16'd20099, 8'd0);
        send_report(16'd20100, 8'd0);
        foreach (cell_values[k]) send_cell_value(cell_values[k]);
    endtask

    task automatic test_config_extremes();
        t_cfg c;
        c = '{pack_resistance_milliohm: 10'd1023, cell_count: 4'd0,
              overvolt_threshold: 8'd255, full_threshold: 8'd255,
              one_bar_threshold: 8'd0, empty_threshold: 8'd0};
        apply_config(c);
        send_report(16'hFFFF, 8'hFF);
        send_report(16'd0, 8'hFF);
        send_cell_value(1);
        send_cell_value(254);
        c = '{pack_resistance_milliohm: 10'd0, cell_count: 4'd15,
              overvolt_threshold: 8'd0, full_threshold: 8'd0,
              one_bar_threshold: 8'd0, empty_threshold: 8'd0};
        apply_config(c);
        send_cell_value(0);
        send_cell_value(1);
        send_report(16'hFFFF, 8'hFF);
    endtask

    task automatic test_special_cases();
        t_cfg c;
        // narrow bar map range
        c = CFG_RESET;
        c.cell_count = 4'd1;
        c.one_bar_threshold = 8'd135;
        c.full_threshold = 8'd140;
        apply_config(c);
        send_cell_value(135);
        send_cell_value(137);
        send_cell_value(139);
        send_cell_value(140);
        // thresholds out of order
        c.overvolt_threshold = 8'd240;
        c.full_threshold = 8'd120;
        c.one_bar_threshold = 8'd160;
        c.empty_threshold = 8'd60;
        apply_config(c);
        send_cell_value(50);
        send_cell_value(70);
        send_cell_value(130);
        send_cell_value(245);
        // write to an unmapped register index has no effect
        settle();
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_cell_value(110);
    endtask

    task automatic test_random(input int send_pct, input int recv_pct);
        t_in rep;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
            apply_config(random_config());
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                if (s == 0 && n == ITEMS_PER_SETTING / 2) settle();
                rep = random_report(gauge_cfg);
                send_report(rep.raw_voltage_mv, rep.current_tenths);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 36;
        recv_idle_pct = 47;
        test_reset_defaults();
        test_config_extremes();
        test_special_cases();
        test_random(36, 47);
        test_random(47, 36);
        test_random(0, 0);
        settle();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
